[design/bdsi_pkg.sv]
// Shared types, constants and helper functions for the burst detector sketch insert block.
// Used by bdsi_ctrl, bdsi_dp and burst_detect_sketch_insert_top; depends on nothing else.
`default_nettype none
package bdsi_pkg;

    localparam int LIGHT_ENTRIES    = 1024;
    localparam int HEAVY_BUCKETS    = 256;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int LIGHT_HASHES     = 4;
    localparam int INDEX_FIELDS     = 4;

    localparam int VAL_W     = 18;
    localparam int ID_W      = 31;
    localparam int TIME_W    = 32;
    localparam int W_W       = 16;
    localparam int BKT_IN_W  = 8;
    localparam int IDX_IN_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam int LI_W  = $clog2(LIGHT_ENTRIES);
    localparam int HB_W  = (HEAVY_BUCKETS > 1) ? $clog2(HEAVY_BUCKETS) : 1;
    localparam int SL_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int LH_W  = $clog2(LIGHT_HASHES);
    localparam int IF_W  = $clog2(INDEX_FIELDS);
    localparam int CLEAR_LEN = (LIGHT_ENTRIES > HEAVY_BUCKETS) ? LIGHT_ENTRIES : HEAVY_BUCKETS;
    localparam int CLR_W = $clog2(CLEAR_LEN);

    // Input request packing, lowest bits first.
    localparam int OFF_ID   = 0;
    localparam int OFF_TIME = OFF_ID + ID_W;
    localparam int OFF_TEMP = OFF_TIME + TIME_W;
    localparam int OFF_BKT  = OFF_TEMP + VAL_W;
    localparam int OFF_LI   = OFF_BKT + BKT_IN_W;
    localparam int IN_BITS  = OFF_LI + INDEX_FIELDS * IDX_IN_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((ID_W + TIME_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_BURST_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEAK_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_W    = 2'd2;

    localparam logic [VAL_W-1:0] BURST_THR_RESET = 18'd78080;
    localparam logic [VAL_W-1:0] WEAK_THR_RESET  = 18'd77568;
    localparam logic [W_W-1:0]   KEEP_W_RESET    = 16'd58982;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [LIGHT_HASHES-1:0][VAL_W-1:0] vec_t;

    typedef struct packed {
        logic [SLOTS_PER_BUCKET-1:0][ID_W-1:0]  ids;
        logic [SLOTS_PER_BUCKET-1:0][VAL_W-1:0] avgs;
    } row_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HCHK,
        ST_HDEC,
        ST_HMUL,
        ST_HUPD,
        ST_HWB,
        ST_LRD,
        ST_LMUL,
        ST_LWR,
        ST_SORT,
        ST_EST,
        ST_PROM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            clear;
        logic            accept;
        logic            hchk;
        logic            hmul;
        logic            hupd;
        logic            hwb;
        logic            lrd;
        logic            lmul;
        logic            lwr;
        logic            sort;
        logic            est;
        logic            prom;
        logic            load_out;
        logic [CLR_W-1:0] clr_addr;
        logic [SL_W-1:0]  slot;
        logic [LH_W-1:0]  hash;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
    } sts_t;

    // Ascending sort of a few narrow values by a small exchange network.
    function automatic vec_t sort_up(input vec_t v);
        vec_t r;
        val_t t;
        r = v;
        for (int i = 0; i < LIGHT_HASHES - 1; i++) begin
            for (int k = 0; k < LIGHT_HASHES - 1 - i; k++) begin
                if (r[k] > r[k+1]) begin
                    t      = r[k];
                    r[k]   = r[k+1];
                    r[k+1] = t;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/burst_detect_sketch_insert_top.sv]
// Top level of the burst detector sketch insert block: stream ports and configuration port.
// Instantiates bdsi_ctrl and bdsi_dp; uses bdsi_pkg.
`default_nettype none
// After reset the block clears its light counters and heavy table, and takes no request
// meanwhile (configuration writes are taken). It then handles one request at a time; the
// time from acceptance to the next acceptance is longer for a flow not found in its heavy
// bucket, and is set by the single shared multiplier of the average unit and the
// read-modify-write of the four light counters through one memory port. One result is
// produced per request and held in an output register, so the next request is taken while
// that result still waits.
module burst_detect_sketch_insert_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // flow_id, sample_time, temperature, heavy_bucket, light_index_0..3, zero fill
    input  wire logic [bdsi_pkg::IN_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // burst_flow, burst_time, zero fill
    output logic [bdsi_pkg::OUT_W-1:0]          m_tdata,
    // burst
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bdsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bdsi_pkg::VAL_W-1:0]     cfg_data
);

    bdsi_pkg::cmd_t cmd;
    bdsi_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bdsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bdsi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

[design/bdsi_ctrl.sv]
// Controller state machine of the burst detector: sequences clearing, heavy and light paths.
// Depends on bdsi_pkg; drives command signals into bdsi_dp and reads its status.
`default_nettype none
module bdsi_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire bdsi_pkg::sts_t sts,
    output bdsi_pkg::cmd_t     cmd
);

    bdsi_pkg::state_t              state_reg, state_next;
    logic [bdsi_pkg::CLR_W-1:0]    clr_reg, clr_next;
    logic [bdsi_pkg::SL_W-1:0]     slot_reg, slot_next;
    logic [bdsi_pkg::LH_W-1:0]     hash_reg, hash_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdsi_pkg::ST_CLEAR;
            clr_reg   <= '0;
            slot_reg  <= '0;
            hash_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            slot_reg  <= slot_next;
            hash_reg  <= hash_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        slot_next    = slot_reg;
        hash_next    = hash_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        cmd.slot     = slot_reg;
        cmd.hash     = hash_reg;
        case (state_reg)
            bdsi_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == bdsi_pkg::CLR_W'(bdsi_pkg::CLEAR_LEN - 1)) begin
                    state_next = bdsi_pkg::ST_IDLE;
                end
            end
            bdsi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = bdsi_pkg::ST_HCHK;
                end
            end
            bdsi_pkg::ST_HCHK: begin
                cmd.hchk   = 1'b1;
                state_next = bdsi_pkg::ST_HDEC;
            end
            bdsi_pkg::ST_HDEC: begin
                slot_next = '0;
                hash_next = '0;
                if (sts.hit) begin
                    state_next = bdsi_pkg::ST_HMUL;
                end else begin
                    state_next = bdsi_pkg::ST_LRD;
                end
            end
            bdsi_pkg::ST_HMUL: begin
                cmd.hmul   = 1'b1;
                state_next = bdsi_pkg::ST_HUPD;
            end
            bdsi_pkg::ST_HUPD: begin
                cmd.hupd = 1'b1;
                if (slot_reg == bdsi_pkg::SL_W'(bdsi_pkg::SLOTS_PER_BUCKET - 1)) begin
                    state_next = bdsi_pkg::ST_HWB;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = bdsi_pkg::ST_HMUL;
                end
            end
            bdsi_pkg::ST_HWB: begin
                cmd.hwb    = 1'b1;
                state_next = bdsi_pkg::ST_DONE;
            end
            bdsi_pkg::ST_LRD: begin
                cmd.lrd    = 1'b1;
                state_next = bdsi_pkg::ST_LMUL;
            end
            bdsi_pkg::ST_LMUL: begin
                cmd.lmul   = 1'b1;
                state_next = bdsi_pkg::ST_LWR;
            end
            bdsi_pkg::ST_LWR: begin
                cmd.lwr = 1'b1;
                if (hash_reg == bdsi_pkg::LH_W'(bdsi_pkg::LIGHT_HASHES - 1)) begin
                    state_next = bdsi_pkg::ST_SORT;
                end else begin
                    hash_next  = hash_reg + 1'b1;
                    state_next = bdsi_pkg::ST_LRD;
                end
            end
            bdsi_pkg::ST_SORT: begin
                cmd.sort   = 1'b1;
                state_next = bdsi_pkg::ST_EST;
            end
            bdsi_pkg::ST_EST: begin
                cmd.est    = 1'b1;
                state_next = bdsi_pkg::ST_PROM;
            end
            bdsi_pkg::ST_PROM: begin
                cmd.prom   = 1'b1;
                state_next = bdsi_pkg::ST_DONE;
            end
            bdsi_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = bdsi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bdsi_pkg::ST_IDLE;
            end
        endcase
    end

    // The bucket check always follows directly on an accepted request.
    a_hchk_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bdsi_pkg::ST_HCHK |-> $past(state_reg) == bdsi_pkg::ST_IDLE
                                           && $past(s_tvalid))
        else $error("bucket check without an accepted request");

    // Once the clearing pass is over, the storage is never cleared again.
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != bdsi_pkg::ST_CLEAR |=> state_reg != bdsi_pkg::ST_CLEAR)
        else $error("clearing pass re-entered");

    // The light path begins at the first hash.
    a_light_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bdsi_pkg::ST_LRD && $past(state_reg) == bdsi_pkg::ST_HDEC
        |-> hash_reg == '0)
        else $error("light path started at a later hash");

endmodule
`default_nettype wire

[design/bdsi_dp.sv]
// Datapath of the burst detector: heavy-row and light-counter memories, shared average unit,
// sort, estimate and promotion logic, configuration registers and result register. Uses bdsi_pkg.
`default_nettype none
module bdsi_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire bdsi_pkg::cmd_t                      cmd,
    output bdsi_pkg::sts_t                           sts,
    input  wire logic [bdsi_pkg::IN_W-1:0]           s_tdata,
    input  wire logic                                cfg_valid,
    input  wire logic [bdsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bdsi_pkg::VAL_W-1:0]          cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bdsi_pkg::OUT_W-1:0]               m_tdata,
    output logic                                     m_tuser
);

    localparam int VW = bdsi_pkg::VAL_W;
    localparam int WW = bdsi_pkg::W_W;
    localparam int MW = WW + VW + 2;

    // Configuration.
    logic [VW-1:0] burst_thr_reg, weak_thr_reg;
    logic [WW-1:0] keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_thr_reg <= bdsi_pkg::BURST_THR_RESET;
            weak_thr_reg  <= bdsi_pkg::WEAK_THR_RESET;
            keep_reg      <= bdsi_pkg::KEEP_W_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bdsi_pkg::REG_BURST_THR: burst_thr_reg <= cfg_data;
                bdsi_pkg::REG_WEAK_THR:  weak_thr_reg  <= cfg_data;
                bdsi_pkg::REG_KEEP_W:    keep_reg      <= cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // Request fields.
    logic [bdsi_pkg::ID_W-1:0]   id_reg;
    logic [bdsi_pkg::TIME_W-1:0] time_reg;
    logic [VW-1:0]               temp_reg;
    logic [bdsi_pkg::HB_W-1:0]   bucket_reg;
    logic [bdsi_pkg::INDEX_FIELDS-1:0][bdsi_pkg::LI_W-1:0] lidx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            id_reg     <= s_tdata[bdsi_pkg::OFF_ID +: bdsi_pkg::ID_W];
            time_reg   <= s_tdata[bdsi_pkg::OFF_TIME +: bdsi_pkg::TIME_W];
            temp_reg   <= s_tdata[bdsi_pkg::OFF_TEMP +: VW];
            bucket_reg <= s_tdata[bdsi_pkg::OFF_BKT +: bdsi_pkg::HB_W];
            for (int k = 0; k < bdsi_pkg::INDEX_FIELDS; k++) begin
                lidx_reg[k] <= s_tdata[bdsi_pkg::OFF_LI + k * bdsi_pkg::IDX_IN_W +: bdsi_pkg::LI_W];
            end
        end
    end

    // Heavy table, one bucket row per entry.
    bdsi_pkg::row_t heavy_mem [bdsi_pkg::HEAVY_BUCKETS];
    bdsi_pkg::row_t heavy_rd_reg, row_reg, row_prom;
    logic           prom_we;
    logic [bdsi_pkg::SLOTS_PER_BUCKET-1:0] match_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            heavy_mem[cmd.clr_addr[bdsi_pkg::HB_W-1:0]] <= '0;
        end else if (cmd.hwb) begin
            heavy_mem[bucket_reg] <= row_reg;
        end else if (cmd.prom && prom_we) begin
            heavy_mem[bucket_reg] <= row_prom;
        end
        if (cmd.accept) begin
            heavy_rd_reg <= heavy_mem[s_tdata[bdsi_pkg::OFF_BKT +: bdsi_pkg::HB_W]];
        end
    end

    // Light counters.
    logic [VW-1:0] light_mem [bdsi_pkg::LIGHT_ENTRIES];
    logic [VW-1:0] light_rd_reg;
    logic [bdsi_pkg::LI_W-1:0] light_addr;
    logic [bdsi_pkg::IF_W-1:0] field_sel;
    logic [VW-1:0] ema;

    assign field_sel  = bdsi_pkg::IF_W'(32'(cmd.hash) % bdsi_pkg::INDEX_FIELDS);
    assign light_addr = lidx_reg[field_sel];

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            light_mem[cmd.clr_addr[bdsi_pkg::LI_W-1:0]] <= '0;
        end else if (cmd.lwr) begin
            light_mem[light_addr] <= ema;
        end
        if (cmd.lrd) begin
            light_rd_reg <= light_mem[light_addr];
        end
    end

    // Shared average unit: new = (s*65536 + w*(prev - s) + 32768) >> 16.
    logic [VW-1:0]        prev_sel;
    logic signed [VW:0]   diff;
    logic signed [MW-1:0] mult_reg;
    logic signed [MW:0]   acc;

    always_comb begin
        if (cmd.hmul) begin
            prev_sel = row_reg.avgs[cmd.slot];
        end else if (light_rd_reg == '0) begin
            prev_sel = temp_reg;
        end else begin
            prev_sel = light_rd_reg;
        end
        diff = $signed({1'b0, prev_sel}) - $signed({1'b0, temp_reg});
        acc  = $signed({3'b000, temp_reg, {WW{1'b0}}}) + (MW+1)'(mult_reg)
               + $signed((MW+1)'(32768));
        ema  = acc[VW+WW-1:WW];
    end

    always_ff @(posedge aclk) begin
        if (cmd.hmul || cmd.lmul) begin
            mult_reg <= $signed({1'b0, keep_reg}) * diff;
        end
    end

    // Light values, estimates and burst flag.
    bdsi_pkg::vec_t oldv_reg, newv_reg;
    logic [VW-1:0]  est_reg;
    logic           burst_reg;
    logic [bdsi_pkg::LH_W-1:0] pick;
    logic [VW-1:0]  gap, best_gap;
    logic [VW:0]    old_sum, new_sum;
    logic [VW-1:0]  old_est, new_est;

    always_comb begin
        pick     = '0;
        best_gap = oldv_reg[1] - oldv_reg[0];
        for (int i = 1; i < bdsi_pkg::LIGHT_HASHES - 1; i++) begin
            gap = oldv_reg[i+1] - oldv_reg[i];
            if (gap < best_gap) begin
                best_gap = gap;
                pick     = bdsi_pkg::LH_W'(i);
            end
        end
        gap     = '0;
        old_sum = {1'b0, oldv_reg[pick]} + {1'b0, oldv_reg[pick + 1'b1]};
        new_sum = {1'b0, newv_reg[pick]} + {1'b0, newv_reg[pick + 1'b1]};
        old_est = old_sum[VW:1];
        new_est = new_sum[VW:1];
    end

    // Promotion above the weak threshold: first empty slot, else the smallest average if beaten.
    always_comb begin
        logic                  claimed;
        logic [bdsi_pkg::SL_W-1:0] victim;
        row_prom = row_reg;
        claimed  = 1'b0;
        victim   = '0;
        prom_we  = 1'b0;
        for (int i = 0; i < bdsi_pkg::SLOTS_PER_BUCKET; i++) begin
            if (!claimed) begin
                if (row_reg.ids[i] == '0) begin
                    claimed          = 1'b1;
                    row_prom.ids[i]  = id_reg;
                    row_prom.avgs[i] = est_reg;
                end else if (row_reg.avgs[i] < row_reg.avgs[victim]) begin
                    victim = bdsi_pkg::SL_W'(i);
                end
            end
        end
        if (!claimed && est_reg > row_reg.avgs[victim]) begin
            row_prom.ids[victim]  = id_reg;
            row_prom.avgs[victim] = est_reg;
        end
        if (est_reg > weak_thr_reg && (claimed || est_reg > row_reg.avgs[victim])) begin
            prom_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hchk) begin
            row_reg <= heavy_rd_reg;
            for (int s = 0; s < bdsi_pkg::SLOTS_PER_BUCKET; s++) begin
                match_reg[s] <= (heavy_rd_reg.ids[s] == id_reg);
            end
        end
        if (cmd.hupd && match_reg[cmd.slot]) begin
            row_reg.avgs[cmd.slot] <= ema;
        end
        if (cmd.lmul) begin
            oldv_reg[cmd.hash] <= light_rd_reg;
        end
        if (cmd.lwr) begin
            newv_reg[cmd.hash] <= ema;
        end
        if (cmd.sort) begin
            oldv_reg <= bdsi_pkg::sort_up(oldv_reg);
            newv_reg <= bdsi_pkg::sort_up(newv_reg);
        end
        if (cmd.est) begin
            est_reg <= new_est;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg <= 1'b0;
        end else if (cmd.accept) begin
            burst_reg <= 1'b0;
        end else if (cmd.hupd && match_reg[cmd.slot] && row_reg.avgs[cmd.slot] <= burst_thr_reg
                     && ema > burst_thr_reg) begin
            burst_reg <= 1'b1;
        end else if (cmd.est && old_est <= burst_thr_reg && new_est > burst_thr_reg) begin
            burst_reg <= 1'b1;
        end
    end

    // Result register.
    logic                         m_tvalid_reg;
    logic [bdsi_pkg::OUT_W-1:0]   m_tdata_reg;
    logic                         m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= bdsi_pkg::OUT_W'({time_reg, id_reg});
            m_tuser_reg <= burst_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;
    assign sts.hit      = |match_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire
